FILE: design/tccw_pkg.sv
// ----------------------------------------------------------------------------
// Text console character writer package
// Request codes, character codes and the stored-character remap.
// ----------------------------------------------------------------------------
package tccw_pkg;

	localparam logic CMD_PUT  = 1'b0;
	localparam logic CMD_READ = 1'b1;

	localparam logic [7:0] CH_BS    = 8'h08;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0a;
	localparam logic [7:0] CH_CR    = 8'h0d;
	localparam logic [7:0] CH_SPACE = 8'h20;

	localparam logic [7:0] CH_YEN_IN   = 8'h5c;
	localparam logic [7:0] CH_YEN_OUT  = 8'hfc;
	localparam logic [7:0] CH_BAR_IN   = 8'h7c;
	localparam logic [7:0] CH_BAR_OUT  = 8'h96;

	function automatic logic [7:0] remap_char(input logic [7:0] ch);
		logic [7:0] r;
		r = ch;
		if (ch == CH_YEN_IN) begin
			r = CH_YEN_OUT;
		end else if (ch == CH_BAR_IN) begin
			r = CH_BAR_OUT;
		end
		return r;
	endfunction

endpackage

FILE: design/text_console_char_writer.sv
// ----------------------------------------------------------------------------
// Text console character writer
// Screen store of ROWS by COLS bytes in one synchronous memory, with cursor,
// control characters and scrolling by a copy walk over the memory.
// ----------------------------------------------------------------------------
// A read goes from ST_IDLE through ST_READ, and a plain character, backspace, carriage
// return or line feed through ST_PUT, to the registered result. A tab writes one space
// per pass through ST_PUT up to the next tab stop. A scroll adds ST_COPY, moving each
// cell up a row, and ST_FILL, blanking the last row; the single memory moves one cell
// per cycle. A request is taken while a result waits in the output register, not while
// one is held in ST_DONE. After reset ST_CLEAR blanks the store before any request.
module text_console_char_writer #(
	parameter int COLS     = 80,
	parameter int ROWS     = 25,
	parameter int TAB_STOP = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        cmd,
	input  logic [7:0]  char_code,
	input  logic [10:0] cell_index,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [10:0] cursor_pos,
	output logic [7:0]  cell_value
);
	import tccw_pkg::*;

	localparam int NCELLS = ROWS * COLS;
	localparam int NCOPY  = NCELLS - COLS;
	localparam int AW     = $clog2(NCELLS);
	localparam int CW     = $clog2(NCELLS + COLS);
	localparam int CLW    = $clog2(COLS);
	localparam int TW     = $clog2(TAB_STOP);
	localparam int NW     = $clog2(TAB_STOP + 1);

	localparam logic [TW-1:0] COLS_MOD    = TW'(COLS % TAB_STOP);
	localparam logic [TW-1:0] LASTCOL_MOD = TW'((COLS - 1) % TAB_STOP);
	localparam logic [TW-1:0] SCRL_MOD    = TW'(NCOPY % TAB_STOP);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_PUT,
		ST_COPY,
		ST_FILL,
		ST_DONE
	} state_t;

	state_t         state_q, state_d;
	logic [CW-1:0]  cursor_q, cursor_d;
	logic [CLW-1:0] col_q, col_d;
	logic [TW-1:0]  cmod_q, cmod_d;
	logic [TW-1:0]  tmod_q, tmod_d;
	logic [AW-1:0]  sc_q, sc_d;
	logic [NW-1:0]  tabn_q, tabn_d;
	logic [7:0]     char_q, char_d;
	logic           in_range_q, in_range_d;
	logic [7:0]     val_q, val_d;
	logic           out_valid_q, out_valid_d;
	logic [10:0]    cursor_pos_q, cursor_pos_d;
	logic [7:0]     cell_value_q, cell_value_d;
	logic           cp_vld_s1, cp_vld_d;
	logic [AW-1:0]  cp_addr_s1, cp_addr_d;

	logic [7:0]     mem [NCELLS];
	logic [7:0]     rdata_q;
	logic           we, re;
	logic [AW-1:0]  wa, ra;
	logic [7:0]     wd;

	assign in_ready   = (state_q == ST_IDLE);
	assign out_valid  = out_valid_q;
	assign cursor_pos = cursor_pos_q;
	assign cell_value = cell_value_q;

	always_comb begin
		logic           fin;
		logic [7:0]     fin_val;
		logic           out_free;
		logic [TW-1:0]  tmod_inc;
		logic [TW-1:0]  tmod_dec;
		logic [TW-1:0]  cmod_inc;
		logic [TW-1:0]  cmod_dec;
		logic [TW:0]    lf_sum;
		logic [CW-1:0]  cur_inc;
		logic [CW-1:0]  cur_lf;
		logic           tab_end;

		fin      = 1'b0;
		fin_val  = 8'h00;
		out_free = !out_valid_q || out_ready;
		tmod_inc = (tmod_q == TW'(TAB_STOP - 1)) ? '0 : tmod_q + TW'(1);
		tmod_dec = (tmod_q == '0) ? TW'(TAB_STOP - 1) : tmod_q - TW'(1);
		cmod_inc = (cmod_q == TW'(TAB_STOP - 1)) ? '0 : cmod_q + TW'(1);
		cmod_dec = (cmod_q == '0) ? TW'(TAB_STOP - 1) : cmod_q - TW'(1);
		lf_sum   = {1'b0, tmod_q} + {1'b0, COLS_MOD};
		cur_inc  = cursor_q + CW'(1);
		cur_lf   = cursor_q + CW'(COLS);
		tab_end  = (tmod_inc == '0) || (tabn_q + NW'(1) == NW'(TAB_STOP));

		state_d      = state_q;
		cursor_d     = cursor_q;
		col_d        = col_q;
		cmod_d       = cmod_q;
		tmod_d       = tmod_q;
		sc_d         = sc_q;
		tabn_d       = tabn_q;
		char_d       = char_q;
		in_range_d   = in_range_q;
		val_d        = val_q;
		out_valid_d  = out_valid_q && !out_ready;
		cursor_pos_d = cursor_pos_q;
		cell_value_d = cell_value_q;
		cp_vld_d     = 1'b0;
		cp_addr_d    = cp_addr_s1;

		we = 1'b0;
		wa = sc_q;
		wd = CH_SPACE;
		re = 1'b0;
		ra = AW'(cell_index);

		unique case (state_q)
			ST_CLEAR: begin
				we = 1'b1;
				if (sc_q == AW'(NCELLS - 1)) begin
					sc_d    = '0;
					state_d = ST_IDLE;
				end else begin
					sc_d = sc_q + AW'(1);
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					char_d     = char_code;
					in_range_d = (32'(cell_index) < NCELLS);
					tabn_d     = '0;
					if (cmd == CMD_READ) begin
						re      = 1'b1;
						state_d = ST_READ;
					end else begin
						state_d = ST_PUT;
					end
				end
			end
			ST_READ: begin
				fin     = 1'b1;
				fin_val = in_range_q ? rdata_q : 8'h00;
			end
			ST_PUT: begin
				case (char_q)
					CH_BS: begin
						fin = 1'b1;
						if (cursor_q != '0) begin
							cursor_d = cursor_q - CW'(1);
							tmod_d   = tmod_dec;
							if (col_q == '0) begin
								col_d  = CLW'(COLS - 1);
								cmod_d = LASTCOL_MOD;
							end else begin
								col_d  = col_q - CLW'(1);
								cmod_d = cmod_dec;
							end
						end
					end
					CH_CR: begin
						fin      = 1'b1;
						cursor_d = cursor_q - CW'(col_q);
						col_d    = '0;
						cmod_d   = '0;
						tmod_d   = (tmod_q >= cmod_q) ? tmod_q - cmod_q
						                              : tmod_q + TW'(TAB_STOP) - cmod_q;
					end
					CH_LF: begin
						if (cur_lf >= CW'(NCELLS)) begin
							sc_d    = '0;
							state_d = ST_COPY;
						end else begin
							fin      = 1'b1;
							cursor_d = cur_lf;
							tmod_d   = (lf_sum >= (TW + 1)'(TAB_STOP))
							           ? TW'(lf_sum - (TW + 1)'(TAB_STOP)) : TW'(lf_sum);
						end
					end
					default: begin
						we     = 1'b1;
						wa     = AW'(cursor_q);
						wd     = (char_q == CH_TAB) ? CH_SPACE : remap_char(char_q);
						tabn_d = tabn_q + NW'(1);
						if (cur_inc == CW'(NCELLS)) begin
							cursor_d = CW'(NCOPY);
							col_d    = '0;
							cmod_d   = '0;
							tmod_d   = SCRL_MOD;
							sc_d     = '0;
							state_d  = ST_COPY;
						end else begin
							cursor_d = cur_inc;
							tmod_d   = tmod_inc;
							if (col_q == CLW'(COLS - 1)) begin
								col_d  = '0;
								cmod_d = '0;
							end else begin
								col_d  = col_q + CLW'(1);
								cmod_d = cmod_inc;
							end
							if (char_q != CH_TAB || tab_end) begin
								fin = 1'b1;
							end
						end
					end
				endcase
			end
			ST_COPY: begin
				we = cp_vld_s1;
				wa = cp_addr_s1;
				wd = rdata_q;
				if (sc_q == AW'(NCOPY)) begin
					state_d = ST_FILL;
				end else begin
					re        = 1'b1;
					ra        = sc_q + AW'(COLS);
					cp_vld_d  = 1'b1;
					cp_addr_d = sc_q;
					sc_d      = sc_q + AW'(1);
				end
			end
			ST_FILL: begin
				we = 1'b1;
				if (sc_q == AW'(NCELLS - 1)) begin
					sc_d = '0;
					if (char_q == CH_TAB && tmod_q != '0 && tabn_q != NW'(TAB_STOP)) begin
						state_d = ST_PUT;
					end else begin
						fin = 1'b1;
					end
				end else begin
					sc_d = sc_q + AW'(1);
				end
			end
			ST_DONE: begin
				if (out_free) begin
					out_valid_d  = 1'b1;
					cursor_pos_d = 11'(cursor_q);
					cell_value_d = val_q;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase

		if (fin) begin
			if (out_free) begin
				out_valid_d  = 1'b1;
				cursor_pos_d = 11'(cursor_d);
				cell_value_d = fin_val;
				state_d      = ST_IDLE;
			end else begin
				val_d   = fin_val;
				state_d = ST_DONE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			cursor_q     <= '0;
			col_q        <= '0;
			cmod_q       <= '0;
			tmod_q       <= '0;
			sc_q         <= '0;
			tabn_q       <= '0;
			out_valid_q  <= 1'b0;
			cursor_pos_q <= '0;
			cell_value_q <= '0;
			cp_vld_s1    <= 1'b0;
		end else begin
			state_q      <= state_d;
			cursor_q     <= cursor_d;
			col_q        <= col_d;
			cmod_q       <= cmod_d;
			tmod_q       <= tmod_d;
			sc_q         <= sc_d;
			tabn_q       <= tabn_d;
			out_valid_q  <= out_valid_d;
			cursor_pos_q <= cursor_pos_d;
			cell_value_q <= cell_value_d;
			cp_vld_s1    <= cp_vld_d;
		end
	end

	always_ff @(posedge clk) begin
		char_q       <= char_d;
		in_range_q   <= in_range_d;
		val_q        <= val_d;
		cp_addr_s1   <= cp_addr_d;
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		if (re) begin
			rdata_q <= mem[ra];
		end
	end

`ifndef ASSERT_OFF
	a_cursor_in_screen: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> cursor_q < CW'(NCELLS))
		else $error("cursor outside the screen while idle");

	a_col_matches_range: assert property (@(posedge clk) disable iff (!arst_n)
		col_q < CLW'(COLS - 1) || col_q == CLW'(COLS - 1))
		else $error("column register out of range");

	a_tab_mod_range: assert property (@(posedge clk) disable iff (!arst_n)
		tmod_q < TW'(TAB_STOP - 1) || tmod_q == TW'(TAB_STOP - 1))
		else $error("tab remainder out of range");

	a_copy_only_in_scroll: assert property (@(posedge clk) disable iff (!arst_n)
		cp_vld_s1 |-> state_q == ST_COPY)
		else $error("copy write pending outside the scroll walk");

	a_ready_only_idle_output: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE) |-> out_valid_q)
		else $error("result held back while the output register is free");
`endif

endmodule

FILE: bench/tb_text_console_char_writer.sv
// ----------------------------------------------------------------------------
// Text console character writer testbench
// Sends put and read requests through the valid/ready request port. Each
// accepted request runs through a software copy of the screen and cursor.
// Every result is then compared with the oldest expected one. Directed
// requests cover the edge cases: edge cells and out-of-range reads, the two
// remapped characters, backspace at the home cell, tabs and line control.
// Random requests follow, long enough to scroll the screen many times.
// ----------------------------------------------------------------------------
module tb_text_console_char_writer;

	timeunit 1ns;
	timeprecision 1ps;

	import tccw_pkg::*;

	localparam int COLS         = 80;
	localparam int ROWS         = 25;
	localparam int TAB_STOP     = 8;
	localparam int CELLS        = ROWS * COLS;
	localparam int RANDOM_ITEMS = 1530;
	localparam int TAIL_CYCLES  = 100;
	localparam int REPORT_LIMIT = 100;

	typedef struct {
		logic [10:0] cursor_pos;
		logic [7:0]  cell_value;
	} console_result_t;

	typedef enum {SINK_OPEN, SINK_CHOPPY, SINK_SLOW} sink_mode_t;

	class console_mirror;
		logic [7:0]      screen [CELLS];
		int unsigned     cursor;
		console_result_t pending_results [$];
		int              errors;

		function new();
			foreach (screen[i]) begin
				screen[i] = CH_SPACE;
			end
			cursor = 0;
			errors = 0;
		endfunction

		function void scroll_at_end();
			if (cursor >= CELLS) begin
				for (int i = 0; i < CELLS - COLS; i++) begin
					screen[i] = screen[i + COLS];
				end
				for (int i = CELLS - COLS; i < CELLS; i++) begin
					screen[i] = CH_SPACE;
				end
				cursor -= COLS;
			end
		endfunction

		function void store_glyph(logic [7:0] ch);
			logic [7:0] glyph;
			glyph = ch;
			if (ch == CH_YEN_IN) begin
				glyph = CH_YEN_OUT;
			end else if (ch == CH_BAR_IN) begin
				glyph = CH_BAR_OUT;
			end
			screen[cursor] = glyph;
			cursor++;
			scroll_at_end();
		endfunction

		function void apply_console_request(logic c, logic [7:0] ch, logic [10:0] idx);
			console_result_t res;
			int unsigned     n;
			res.cell_value = '0;
			if (c == CMD_READ) begin
				if (idx < CELLS) begin
					res.cell_value = screen[idx];
				end
			end else begin
				case (ch)
					CH_TAB: begin
						n = 0;
						do begin
							store_glyph(CH_SPACE);
							n++;
						end while ((cursor % TAB_STOP) != 0 && n < TAB_STOP);
					end
					CH_BS: begin
						if (cursor > 0) begin
							cursor--;
						end
					end
					CH_CR: begin
						cursor -= cursor % COLS;
					end
					CH_LF: begin
						cursor += COLS;
						scroll_at_end();
					end
					default: begin
						store_glyph(ch);
					end
				endcase
			end
			res.cursor_pos = cursor[10:0];
			pending_results.push_back(res);
		endfunction

		function void check_console_result(logic [10:0] pos, logic [7:0] value);
			console_result_t want;
			if (pending_results.size() == 0) begin
				errors++;
				if (errors <= REPORT_LIMIT) begin
					$display("%0d ns: result with no request pending, expected none, actual %0d/%0h",
						$time, pos, value);
				end
				return;
			end
			want = pending_results.pop_front();
			if (pos !== want.cursor_pos) begin
				errors++;
				if (errors <= REPORT_LIMIT) begin
					$display("%0d ns: cursor_pos expected %0d, actual %0d",
						$time, want.cursor_pos, pos);
				end
			end
			if (value !== want.cell_value) begin
				errors++;
				if (errors <= REPORT_LIMIT) begin
					$display("%0d ns: cell_value expected %02h, actual %02h",
						$time, want.cell_value, value);
				end
			end
		endfunction
	endclass

	logic        clk        = 1'b0;
	logic        arst_n     = 1'b0;
	logic        in_valid   = 1'b0;
	logic        in_ready;
	logic        cmd        = CMD_PUT;
	logic [7:0]  char_code  = '0;
	logic [10:0] cell_index = '0;
	logic        out_valid;
	logic        out_ready  = 1'b0;
	logic [10:0] cursor_pos;
	logic [7:0]  cell_value;

	sink_mode_t  sink_mode = SINK_OPEN;
	int          sink_left = 0;

	console_mirror mirror;

	text_console_char_writer #(
		.COLS(COLS),
		.ROWS(ROWS),
		.TAB_STOP(TAB_STOP)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.cmd(cmd),
		.char_code(char_code),
		.cell_index(cell_index),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.cursor_pos(cursor_pos),
		.cell_value(cell_value)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (sink_left == 0) begin
			sink_mode <= sink_mode_t'($urandom_range(0, 2));
			sink_left <= $urandom_range(16, 300);
		end else begin
			sink_left <= sink_left - 1;
		end
		case (sink_mode)
			SINK_OPEN: out_ready <= 1'b1;
			SINK_CHOPPY: out_ready <= 1'($urandom_range(0, 1));
			default: out_ready <= ($urandom_range(0, 3) == 0);
		endcase
	end

	always @(posedge clk) begin
		if (out_valid === 1'b1 && out_ready) begin
			mirror.check_console_result(cursor_pos, cell_value);
		end
		if (in_valid && in_ready === 1'b1) begin
			mirror.apply_console_request(cmd, char_code, cell_index);
		end
	end

	task automatic send_request(logic c, logic [7:0] ch, logic [10:0] idx);
		in_valid   <= 1'b1;
		cmd        <= c;
		char_code  <= ch;
		cell_index <= idx;
		@(posedge clk);
		while (in_ready !== 1'b1) begin
			@(posedge clk);
		end
	endtask

	task automatic put_char(logic [7:0] ch);
		send_request(CMD_PUT, ch, 11'($urandom_range(0, 2047)));
	endtask

	task automatic read_cell(logic [10:0] idx);
		send_request(CMD_READ, 8'($urandom_range(0, 255)), idx);
	endtask

	task automatic idle_sender(int cycles);
		in_valid <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	function automatic logic [7:0] pick_char();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) begin
			return 8'($urandom_range(8'h21, 8'h7e));
		end else if (r < 62) begin
			return CH_LF;
		end else if (r < 67) begin
			return CH_CR;
		end else if (r < 72) begin
			return CH_BS;
		end else if (r < 78) begin
			return CH_TAB;
		end else if (r < 80) begin
			return CH_YEN_IN;
		end else if (r < 82) begin
			return CH_BAR_IN;
		end else if (r < 85) begin
			return CH_SPACE;
		end
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic logic [10:0] pick_cell();
		int unsigned off;
		case ($urandom_range(0, 9))
			0: return 11'($urandom_range(CELLS, 2047));
			1, 2, 3: return 11'($urandom_range(0, CELLS - 1));
			default: begin
				off = $urandom_range(0, 2 * COLS);
				if (mirror.cursor >= off) begin
					return 11'(mirror.cursor - off);
				end
				return 11'(mirror.cursor);
			end
		endcase
	endfunction

	initial begin
		int sent;
		int burst;
		mirror = new();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		read_cell(11'd0);
		read_cell(11'(CELLS - 1));
		read_cell(11'(CELLS));
		read_cell(11'h7ff);
		put_char(8'h41);
		put_char(CH_YEN_IN);
		put_char(CH_BAR_IN);
		read_cell(11'd1);
		read_cell(11'd2);
		repeat (4) put_char(CH_BS);
		put_char(CH_TAB);
		put_char(8'hff);
		put_char(CH_TAB);
		put_char(8'h00);
		put_char(CH_CR);
		put_char(CH_LF);
		read_cell(11'd8);
		read_cell(11'd16);

		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			burst = $urandom_range(1, 40);
			for (int k = 0; k < burst && sent < RANDOM_ITEMS; k++) begin
				if ($urandom_range(0, 9) < 3) begin
					read_cell(pick_cell());
				end else begin
					put_char(pick_char());
				end
				sent++;
			end
			if ($urandom_range(0, 3) != 0) begin
				idle_sender($urandom_range(1, 15));
			end
		end
		in_valid <= 1'b0;
		@(posedge clk);

		while (mirror.pending_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mirror.errors == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	initial begin
		#250_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
